// File: hw/rtl/blf_pkg.sv
// Shared types, widths and constants for the button triggered LED fade block.
package blf_pkg;

  localparam int PERIOD_W   = 16;
  localparam int PPL_W      = 8;
  localparam int LEVEL_W    = 7;
  localparam int DELAY_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Brightness is a percentage; on-time is level * period / PCT_SCALE.
  localparam int PCT_SCALE = 100;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(100);

  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST    = PERIOD_W'(1250);
  localparam logic [PPL_W-1:0]    PPL_RST           = PPL_W'(24);
  localparam logic [LEVEL_W-1:0]  START_LEVEL_RST   = LEVEL_W'(100);
  localparam logic [DELAY_W-1:0]  DEBOUNCE_RST      = DELAY_W'(20000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PPL         = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = CFG_IDX_W'(3);

  typedef struct packed {
    logic [PERIOD_W-1:0] period_len;
    logic [PPL_W-1:0]    level_periods;
    logic [LEVEL_W-1:0]  start_level;
    logic [DELAY_W-1:0]  debounce_us;
  } cfg_t;

  typedef struct packed {
    logic               red_led;
    logic               green_led;
    logic               fading;
    logic [LEVEL_W-1:0] level_now;
  } result_t;

endpackage

// File: hw/rtl/blf_if.sv
// Valid/ready channel interfaces for the button input, LED result and configuration write.
interface blf_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface blf_out_if import blf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               red_led;
  logic               green_led;
  logic               fading;
  logic [LEVEL_W-1:0] level_now;

  modport source (output valid, output red_led, output green_led, output fading,
                  output level_now, input ready);
  modport sink   (input valid, input red_led, input green_led, input fading,
                  input level_now, output ready);
endinterface

interface blf_cfg_if import blf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/blf_cfg_regs.sv
// Configuration register file written through the configuration channel.
module blf_cfg_regs import blf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  blf_cfg_if.sink  cfg_ch,
  output cfg_t     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PWM_PERIOD:  cfg_nxt.period_len    = cfg_ch.data[PERIOD_W-1:0];
        REG_PPL:         cfg_nxt.level_periods = cfg_ch.data[PPL_W-1:0];
        REG_START_LEVEL: cfg_nxt.start_level   = cfg_ch.data[LEVEL_W-1:0];
        REG_DEBOUNCE:    cfg_nxt.debounce_us   = cfg_ch.data[DELAY_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_len    <= PWM_PERIOD_RST;
      cfg_r.level_periods <= PPL_RST;
      cfg_r.start_level   <= START_LEVEL_RST;
      cfg_r.debounce_us   <= DEBOUNCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hw/rtl/blf_fade_core.sv
// Debounce, settle and PWM fade sequencer; one step per tick with a registered result.
module blf_fade_core import blf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    step_en,
  input  logic    button_level,
  output result_t res
);

  typedef enum logic [2:0] {
    PH_WAIT_PRESS   = 3'd0,
    PH_DEBOUNCE     = 3'd1,
    PH_WAIT_RELEASE = 3'd2,
    PH_SETTLE       = 3'd3,
    PH_FADE         = 3'd4
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [DELAY_W-1:0]  delay_r, delay_nxt;
  logic [PPL_W-1:0]    period_cnt_r, period_cnt_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic                green_r, green_nxt;
  result_t             res_r, res_nxt;

  logic [PERIOD_W-1:0]         per;
  logic [PPL_W-1:0]            ppl;
  logic [DELAY_W:0]            delay_inc;
  logic [PPL_W:0]              period_inc;
  logic [LEVEL_W+PERIOD_W-1:0] on_prod;
  logic [DELAY_W+7:0]          pos_scaled;
  logic                        led_on;
  logic                        period_done;
  logic                        level_done;
  logic                        delay_done;

  assign res = res_r;

  always_comb begin
    per         = (cfg.period_len == '0) ? PERIOD_W'(1) : cfg.period_len;
    ppl         = (cfg.level_periods == '0) ? PPL_W'(1) : cfg.level_periods;
    delay_inc   = {1'b0, delay_r} + (DELAY_W+1)'(1);
    period_inc  = {1'b0, period_cnt_r} + (PPL_W+1)'(1);
    // The LED is on while position < floor(level*per/100), which is the same
    // as 100*(position+1) <= level*per, so no divider is needed.
    on_prod     = (LEVEL_W+PERIOD_W)'(level_r) * (LEVEL_W+PERIOD_W)'(per);
    pos_scaled  = (DELAY_W+8)'(delay_inc) * (DELAY_W+8)'(PCT_SCALE);
    led_on      = pos_scaled <= (DELAY_W+8)'(on_prod);
    period_done = delay_inc >= {1'b0, per};
    level_done  = period_inc >= {1'b0, ppl};
    delay_done  = delay_r >= cfg.debounce_us;

    phase_nxt      = phase_r;
    delay_nxt      = delay_r;
    period_cnt_nxt = period_cnt_r;
    level_nxt      = level_r;
    green_nxt      = green_r;
    res_nxt        = '0;

    case (phase_r)
      PH_DEBOUNCE: begin
        if (delay_done) begin
          phase_nxt = button_level ? PH_WAIT_RELEASE : PH_WAIT_PRESS;
          delay_nxt = '0;
        end else begin
          delay_nxt = delay_inc[DELAY_W-1:0];
        end
      end
      PH_WAIT_RELEASE: begin
        if (!button_level) begin
          phase_nxt = PH_SETTLE;
          delay_nxt = '0;
        end
      end
      PH_SETTLE: begin
        if (delay_done) begin
          phase_nxt      = PH_FADE;
          delay_nxt      = '0;
          period_cnt_nxt = '0;
          level_nxt      = (cfg.start_level > MAX_LEVEL) ? MAX_LEVEL : cfg.start_level;
        end else begin
          delay_nxt = delay_inc[DELAY_W-1:0];
        end
      end
      PH_FADE: begin
        res_nxt.fading    = 1'b1;
        res_nxt.level_now = level_r;
        res_nxt.red_led   = led_on && !green_r;
        res_nxt.green_led = led_on && green_r;
        if (period_done) begin
          delay_nxt = '0;
          if (level_done) begin
            period_cnt_nxt = '0;
            if (level_r == '0) begin
              // Fade finished: swap colors for the next press.
              phase_nxt = PH_WAIT_PRESS;
              green_nxt = !green_r;
            end else begin
              level_nxt = level_r - LEVEL_W'(1);
            end
          end else begin
            period_cnt_nxt = period_inc[PPL_W-1:0];
          end
        end else begin
          delay_nxt = delay_inc[DELAY_W-1:0];
        end
      end
      default: begin
        // Waiting for a press; unused codes land here as well.
        if (button_level) begin
          phase_nxt = PH_DEBOUNCE;
          delay_nxt = '0;
        end else begin
          phase_nxt = PH_WAIT_PRESS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT_PRESS;
      delay_r      <= '0;
      period_cnt_r <= '0;
      level_r      <= '0;
      green_r      <= 1'b0;
      res_r        <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      delay_r      <= delay_nxt;
      period_cnt_r <= period_cnt_nxt;
      level_r      <= level_nxt;
      green_r      <= green_nxt;
      res_r        <= res_nxt;
    end
  end

  a_one_color: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_r.red_led && res_r.green_led))
    else $error("both LEDs driven in the same tick");

  a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
    !res_r.fading |-> (res_r.level_now == '0 && !res_r.red_led && !res_r.green_led))
    else $error("LED or level active outside a fade");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= MAX_LEVEL)
    else $error("fade level above full scale");

  a_color_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && phase_r == PH_FADE && phase_nxt == PH_WAIT_PRESS) |=> green_r != $past(green_r))
    else $error("color did not alternate at fade end");

endmodule

// File: hw/rtl/button_triggered_led_fade.sv
// Top level of the debounced button triggered two-color LED fade controller.
//
// Usage: the in_ch channel carries one request per microsecond tick with the
// sampled button level. The out_ch channel returns exactly one result request
// per input request, in order: the red and green LED drive, a fading flag and
// the current fade level (zero when no fade is running). The cfg_ch channel
// writes the PWM period, periods per level, start level and debounce delay;
// it is always ready and should only be used while no requests are in flight.
// A request accepted on in_ch sits in the input register, the sequencer step
// loads its result into the result register, and out_ch offers the result from
// that register. The block takes one request per cycle while the receiver
// does not stall, as the fade sequencer makes a single step for each tick.
// When the receiver stalls, the result register holds its request and the
// input register absorbs one more; in_ch.ready drops only when both are full.
// Synchronous reset clears the pipeline, returns the sequencer to waiting for
// a press with red as the next color, and restores all register defaults.
module button_triggered_led_fade import blf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  blf_in_if.sink    in_ch,
  blf_out_if.source out_ch,
  blf_cfg_if.sink   cfg_ch
);

  cfg_t    cfg;
  result_t res;

  logic in_valid_r, in_valid_nxt;
  logic button_r, button_nxt;
  logic out_valid_r, out_valid_nxt;
  logic step_en;

  // The sequencer steps whenever a tick sits in the input register and the
  // result register is free or being emptied in this cycle.
  assign step_en     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step_en;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    button_nxt    = button_r;
    out_valid_nxt = out_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      in_valid_nxt = 1'b1;
      button_nxt   = in_ch.button_level;
    end else if (step_en) begin
      in_valid_nxt = 1'b0;
    end
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    button_r <= button_nxt;
  end

  blf_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  blf_fade_core u_fade_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .step_en      (step_en),
    .button_level (button_r),
    .res          (res)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_led   = res.red_led;
  assign out_ch.green_led = res.green_led;
  assign out_ch.fading    = res.fading;
  assign out_ch.level_now = res.level_now;

  // A request waiting in the input register is never dropped or altered.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !step_en) |=> (in_valid_r && $stable(button_r)))
    else $error("pending input request lost while stalled");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the button triggered LED fade block, with its own tick predictor.
module tb;
  import blf_pkg::*;

  // The watchdog limit is several times the slowest legal run. That run is
  // about six hundred tick requests plus a few dozen register writes, each
  // slowed by sender gaps and receiver stalls.
  localparam int unsigned CYCLE_LIMIT = 20_000;
  localparam int unsigned IDLE_PCT    = 23;

  // Sequencer phases as the predictor tracks them.
  typedef enum logic [2:0] {
    PH_WAIT_PRESS   = 3'd0,
    PH_DEBOUNCE     = 3'd1,
    PH_WAIT_RELEASE = 3'd2,
    PH_SETTLE       = 3'd3,
    PH_FADE         = 3'd4
  } fade_phase_t;

  logic clk = 1'b0;
  logic rst_n;

  blf_in_if  in_ch ();
  blf_out_if out_ch ();
  blf_cfg_if cfg_ch ();

  button_triggered_led_fade i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 8 time unit clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers and of the sequencer state.
  cfg_t        led_cfg;
  fade_phase_t fsm_phase;
  logic [DELAY_W-1:0] tick_count;
  logic [PPL_W-1:0]   period_idx;
  logic [LEVEL_W-1:0] fade_level;
  logic               use_green;

  // LED results predicted for accepted tick requests, oldest first.
  result_t expected_leds_q[$];

  int unsigned error_count;
  int unsigned ticks_sent;
  int unsigned fades_done;
  int unsigned cfg_writes;
  int unsigned cycle_count;
  logic        idle_on;

  // Advances the predicted sequencer by one microsecond tick and returns the
  // LED result that this tick produces.
  function automatic result_t led_tick_model(input logic pressed);
    result_t     r;
    int unsigned per;
    int unsigned ppl;
    int unsigned on_time;
    r = '0;
    case (fsm_phase)
      PH_DEBOUNCE: begin
        // The sample after the full count decides whether the press holds.
        if (tick_count >= led_cfg.debounce_us) begin
          fsm_phase  = pressed ? PH_WAIT_RELEASE : PH_WAIT_PRESS;
          tick_count = '0;
        end else begin
          tick_count++;
        end
      end
      PH_WAIT_RELEASE: begin
        if (!pressed) begin
          fsm_phase  = PH_SETTLE;
          tick_count = '0;
        end
      end
      PH_SETTLE: begin
        if (tick_count >= led_cfg.debounce_us) begin
          fsm_phase  = PH_FADE;
          tick_count = '0;
          period_idx = '0;
          fade_level = (led_cfg.start_level > MAX_LEVEL) ? MAX_LEVEL : led_cfg.start_level;
        end else begin
          tick_count++;
        end
      end
      PH_FADE: begin
        // A zero period or zero periods per level behaves as one.
        per     = (led_cfg.period_len == '0) ? 1 : led_cfg.period_len;
        ppl     = (led_cfg.level_periods == '0) ? 1 : led_cfg.level_periods;
        on_time = (fade_level * per) / PCT_SCALE;
        r.fading    = 1'b1;
        r.level_now = fade_level;
        if (tick_count < on_time) begin
          if (use_green) r.green_led = 1'b1;
          else r.red_led = 1'b1;
        end
        // The period ends as soon as its position reaches the current
        // length, even when the length was lowered mid-period.
        if (tick_count + 1 >= per) begin
          tick_count = '0;
          if (period_idx + 1 >= ppl) begin
            period_idx = '0;
            if (fade_level == '0) begin
              fsm_phase = PH_WAIT_PRESS;
              use_green = !use_green;
              fades_done++;
            end else begin
              fade_level--;
            end
          end else begin
            period_idx++;
          end
        end else begin
          tick_count++;
        end
      end
      default: begin
        if (pressed) begin
          fsm_phase  = PH_DEBOUNCE;
          tick_count = '0;
        end else begin
          fsm_phase = PH_WAIT_PRESS;
        end
      end
    endcase
    return r;
  endfunction

  // Sends one tick request. It is entered at a falling edge, leaves valid
  // high and returns at the falling edge after acceptance.
  task automatic send_tick(input logic pressed);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid        <= 1'b0;
      in_ch.button_level <= 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.button_level <= pressed;
    do @(posedge clk); while (!in_ch.ready);
    expected_leds_q.push_back(led_tick_model(pressed));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_leds_q.size() != 0) @(negedge clk);
  endtask

  // Writes one register. It is only called with no requests in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_PWM_PERIOD:  led_cfg.period_len    = value;
      REG_PPL:         led_cfg.level_periods = value[PPL_W-1:0];
      REG_START_LEVEL: led_cfg.start_level   = value[LEVEL_W-1:0];
      REG_DEBOUNCE:    led_cfg.debounce_us   = value;
      default:         ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Feeds random button noise while the predicted sequencer is settling or
  // fading, so the fade always runs to its end.
  task automatic finish_fade();
    while (fsm_phase == PH_SETTLE || fsm_phase == PH_FADE) send_tick(1'($urandom));
  endtask

  // One press of the button. A well-formed press is held past the debounce
  // so it is confirmed; otherwise it is let go early and rejected.
  task automatic button_session(input logic well_formed);
    int unsigned deb;
    int unsigned hold;
    deb = led_cfg.debounce_us;
    repeat ($urandom_range(3)) send_tick(1'b0);
    if (well_formed) hold = deb + 2 + $urandom_range(3);
    else hold = $urandom_range(deb + 1, 1);
    repeat (hold) send_tick(1'b1);
    send_tick(1'b0);
    // A little contact bounce on release.
    repeat ($urandom_range(2)) send_tick($urandom_range(99) < 20);
    finish_fade();
  endtask

  task automatic pick_small_config();
    if ($urandom_range(9) == 0) begin
      // A clamped start level with the shortest periods keeps the fade brief.
      write_reg(REG_PWM_PERIOD, 16'd1);
      write_reg(REG_PPL, 16'd1);
      write_reg(REG_START_LEVEL, 16'($urandom_range(127, 100)));
    end else begin
      write_reg(REG_PWM_PERIOD, 16'($urandom_range(6)));
      write_reg(REG_PPL, 16'($urandom_range(3)));
      write_reg(REG_START_LEVEL, 16'($urandom_range(5)));
    end
    write_reg(REG_DEBOUNCE, 16'($urandom_range(4)));
  endtask

  // With the reset registers the LEDs stay dark; a short press only starts
  // the long default debounce.
  task automatic test_defaults_after_reset();
    repeat (6) send_tick(1'b0);
    repeat (4) send_tick(1'b1);
    wait_results_drained();
  endtask

  // Short registers: a rejected glitch, then a confirmed press and a full three-level fade
  // on red, dark as its on-time is zero. Upper data bits of narrow registers are dropped.
  task automatic test_directed_fade();
    write_reg(REG_PWM_PERIOD, 16'd3);
    write_reg(REG_PPL, 16'hAB01);
    write_reg(REG_START_LEVEL, 16'hFF82);
    write_reg(REG_DEBOUNCE, 16'd0);
    // The debounce already running from the previous test is rejected.
    send_tick(1'b0);
    // A one-tick glitch is rejected too.
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    finish_fade();
    send_tick(1'b0);
    wait_results_drained();
  endtask

  // Zero period and zero periods per level act as one; a start level above
  // 100 is clamped. Then the largest periods per level with a dark fade.
  // This test runs with no idling on either side.
  task automatic test_zero_and_clamped_regs();
    idle_on = 1'b0;
    write_reg(REG_PWM_PERIOD, 16'd0);
    write_reg(REG_PPL, 16'd0);
    write_reg(REG_START_LEVEL, 16'd127);
    write_reg(REG_DEBOUNCE, 16'd0);
    button_session(1'b1);
    wait_results_drained();
    write_reg(REG_PWM_PERIOD, 16'd1);
    write_reg(REG_PPL, 16'd255);
    write_reg(REG_START_LEVEL, 16'd0);
    button_session(1'b1);
    wait_results_drained();
    idle_on = 1'b1;
  endtask

  // The largest period at level 1 gives 655 on-ticks; 30 ticks in, the
  // period is cut to three ticks, which must end the running period at once.
  task automatic test_period_change_mid_fade();
    write_reg(REG_PWM_PERIOD, 16'hFFFF);
    write_reg(REG_PPL, 16'd1);
    write_reg(REG_START_LEVEL, 16'd1);
    write_reg(REG_DEBOUNCE, 16'd2);
    repeat (4) send_tick(1'b1);
    send_tick(1'b0);
    while (fsm_phase == PH_SETTLE) send_tick(1'($urandom));
    repeat (30) send_tick(1'($urandom));
    wait_results_drained();
    write_reg(REG_PWM_PERIOD, 16'd3);
    write_reg(REG_PPL, 16'd2);
    finish_fade();
    wait_results_drained();
  endtask

  // A full-scale debounce only counts; lowering it below the running count
  // confirms the press on the next tick, and a one-tick dark fade follows.
  task automatic test_full_debounce();
    write_reg(REG_DEBOUNCE, 16'hFFFF);
    write_reg(REG_PWM_PERIOD, 16'd1);
    write_reg(REG_PPL, 16'd1);
    write_reg(REG_START_LEVEL, 16'd0);
    repeat (6) send_tick(1'b1);
    wait_results_drained();
    write_reg(REG_DEBOUNCE, 16'd3);
    send_tick(1'b1);
    send_tick(1'b0);
    finish_fade();
    wait_results_drained();
  endtask

  // Mostly well-formed presses with random timing under small random
  // registers.
  task automatic test_random_sessions(input int unsigned n_ticks);
    int unsigned start_ticks;
    int unsigned sessions;
    start_ticks = ticks_sent;
    sessions    = 0;
    while (ticks_sent - start_ticks < n_ticks) begin
      if (sessions % 4 == 0) begin
        wait_results_drained();
        pick_small_config();
      end else if ($urandom_range(9) == 0) begin
        wait_results_drained();
      end
      button_session($urandom_range(99) < 80);
      sessions++;
    end
  endtask

  // The receiver stalls at random, except during the idle-free stretch.
  always @(negedge clk) begin
    out_ch.ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  // Every accepted result request is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_leds_q.size() == 0) begin
        $error("LED result request arrived with no prediction pending");
        error_count++;
      end else begin
        want = expected_leds_q.pop_front();
        if (out_ch.red_led !== want.red_led) begin
          $error("red_led: expected %0b, got %0b", want.red_led, out_ch.red_led);
          error_count++;
        end
        if (out_ch.green_led !== want.green_led) begin
          $error("green_led: expected %0b, got %0b", want.green_led, out_ch.green_led);
          error_count++;
        end
        if (out_ch.fading !== want.fading) begin
          $error("fading: expected %0b, got %0b", want.fading, out_ch.fading);
          error_count++;
        end
        if (out_ch.level_now !== want.level_now) begin
          $error("level_now: expected %0d, got %0d", want.level_now, out_ch.level_now);
          error_count++;
        end
      end
    end
  end

  // A run that hangs, for instance on a lost result, ends here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.button_level = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_PWM_PERIOD;
    cfg_ch.data        = '0;
    out_ch.ready       = 1'b0;
    idle_on            = 1'b1;
    rst_n              = 1'b0;
    error_count        = 0;
    ticks_sent         = 0;
    fades_done         = 0;
    cfg_writes         = 0;

    // Predictor starts from the reset state: default registers, waiting
    // for a press, red first.
    led_cfg.period_len    = PWM_PERIOD_RST;
    led_cfg.level_periods = PPL_RST;
    led_cfg.start_level   = START_LEVEL_RST;
    led_cfg.debounce_us   = DEBOUNCE_RST;
    fsm_phase  = PH_WAIT_PRESS;
    tick_count = '0;
    period_idx = '0;
    fade_level = '0;
    use_green  = 1'b0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_defaults_after_reset();
    test_directed_fade();
    test_zero_and_clamped_regs();
    test_period_change_mid_fade();
    test_full_debounce();
    test_random_sessions(120);

    // Let the two-stage pipeline empty, then keep watching for any stray result request.
    wait_results_drained();
    repeat (8) @(posedge clk);

    $display("Run covered %0d tick requests, %0d completed fades and %0d register writes,",
             ticks_sent, fades_done, cfg_writes);
    $display("including zero and full-scale registers and a period cut short mid-fade.");
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
